### rtl/signed_integer_radix_print_macros.svh
// assertion macros shared by the radix printer modules
`ifndef SIGNED_INTEGER_RADIX_PRINT_MACROS_SVH
`define SIGNED_INTEGER_RADIX_PRINT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SIRP_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SIRP_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### rtl/sirp_pkg.sv
// types, constants and helper functions for the signed radix printer
package sirp_pkg;

  localparam int unsigned ADDR_W          = 5;
  localparam int unsigned DATA_W          = 64;
  localparam int unsigned RADIX_W         = 5;
  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned NUM_CHARS       = 16;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned POS_W           = 5;
  localparam int unsigned WORK_W          = VALUE_W + 1;
  localparam int unsigned DEC_W           = 34;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // register indexes, taken from paddr[4:3]
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_RADIX_LEN  = 2'd0;
  localparam reg_idx_t REG_ALPHA_LOW  = 2'd1;
  localparam reg_idx_t REG_ALPHA_HIGH = 2'd2;

  // radix length codes
  localparam logic [RADIX_W-1:0] LEN_BIN = 5'd2;
  localparam logic [RADIX_W-1:0] LEN_OCT = 5'd8;
  localparam logic [RADIX_W-1:0] LEN_DEC = 5'd10;
  localparam logic [RADIX_W-1:0] LEN_HEX = 5'd16;

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;

  // top digit position of a full 32-bit magnitude per radix
  localparam logic [POS_W-1:0] TOP_POS_BIN = 5'd31;
  localparam logic [POS_W-1:0] TOP_POS_OCT = 5'd10;
  localparam logic [POS_W-1:0] TOP_POS_DEC = 5'd9;
  localparam logic [POS_W-1:0] TOP_POS_HEX = 5'd7;

  typedef enum logic [1:0] {
    RADIX_BIN,
    RADIX_OCT,
    RADIX_DEC,
    RADIX_HEX
  } radix_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SIGN,
    BK_DIGIT
  } back_state_t;

  typedef struct packed {
    logic [RADIX_W-1:0] radix_len;
    logic [DATA_W-1:0]  alpha_low;
    logic [DATA_W-1:0]  alpha_high;
  } cfg_t;

  typedef struct packed {
    radix_t             radix;
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

  // alphabet character for digit k
  function automatic logic [CHAR_W-1:0] alpha_char(cfg_t cfg, logic [DIGIT_W-1:0] k);
    logic [2*DATA_W-1:0] all;
    all = {cfg.alpha_high, cfg.alpha_low};
    return all[k*CHAR_W +: CHAR_W];
  endfunction

  // power of ten at a decimal position
  function automatic logic [DEC_W-1:0] dec_pow(logic [3:0] pos);
    logic [DEC_W-1:0] p;
    case (pos)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

  // first digit position for a radix
  function automatic logic [POS_W-1:0] top_pos(radix_t r);
    logic [POS_W-1:0] p;
    case (r)
      RADIX_BIN: p = TOP_POS_BIN;
      RADIX_OCT: p = TOP_POS_OCT;
      RADIX_DEC: p = TOP_POS_DEC;
      RADIX_HEX: p = TOP_POS_HEX;
      default:   p = TOP_POS_BIN;
    endcase
    return p;
  endfunction

endpackage

### rtl/sirp_cfg.sv
// apb configuration registers: radix length and digit alphabet
module sirp_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sirp_pkg::ADDR_W-1:0] paddr,
  input  logic [sirp_pkg::DATA_W-1:0] pwdata,
  output logic [sirp_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output sirp_pkg::cfg_t              cfg
);
  import sirp_pkg::*;

  logic [RADIX_W-1:0] radix_len;
  logic [DATA_W-1:0]  alpha_low;
  logic [DATA_W-1:0]  alpha_high;
  reg_idx_t           idx;
  logic               wr_en;

  assign idx    = paddr[ADDR_W-1:3];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_len  <= '0;
      alpha_low  <= '0;
      alpha_high <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_RADIX_LEN:  radix_len  <= pwdata[RADIX_W-1:0];
        REG_ALPHA_LOW:  alpha_low  <= pwdata;
        REG_ALPHA_HIGH: alpha_high <= pwdata;
        default:        ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_RADIX_LEN:  prdata = {{(DATA_W-RADIX_W){1'b0}}, radix_len};
      REG_ALPHA_LOW:  prdata = alpha_low;
      REG_ALPHA_HIGH: prdata = alpha_high;
      default:        prdata = '0;
    endcase
  end

  assign cfg.radix_len  = radix_len;
  assign cfg.alpha_low  = alpha_low;
  assign cfg.alpha_high = alpha_high;

endmodule

### rtl/sirp_front.sv
// front end: accepts values, checks the alphabet and classifies the radix
module sirp_front (
  input  logic                         start,
  input  logic [sirp_pkg::VALUE_W-1:0] value,
  input  sirp_pkg::cfg_t               cfg,
  input  logic                         q_full,
  output logic                         busy,
  output logic                         push,
  output sirp_pkg::item_t              item
);
  import sirp_pkg::*;

  logic   len_ok;
  logic   alpha_ok;
  radix_t radix;
  logic   neg;

  // radix from alphabet length
  always_comb begin
    len_ok = 1'b1;
    case (cfg.radix_len)
      LEN_BIN: radix = RADIX_BIN;
      LEN_OCT: radix = RADIX_OCT;
      LEN_DEC: radix = RADIX_DEC;
      LEN_HEX: radix = RADIX_HEX;
      default: begin
        radix  = RADIX_BIN;
        len_ok = 1'b0;
      end
    endcase
  end

  // sign characters and repeats among the characters in use
  always_comb begin
    alpha_ok = 1'b1;
    for (int i = 0; i < NUM_CHARS; i++) begin
      if (RADIX_W'(i) < cfg.radix_len) begin
        if (alpha_char(cfg, DIGIT_W'(i)) == MINUS_CHAR ||
            alpha_char(cfg, DIGIT_W'(i)) == PLUS_CHAR) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < NUM_CHARS; j++) begin
          if (RADIX_W'(j) < cfg.radix_len &&
              alpha_char(cfg, DIGIT_W'(i)) == alpha_char(cfg, DIGIT_W'(j))) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // sign and magnitude; the most negative value wraps to 2^31 unsigned
  assign neg        = value[VALUE_W-1];
  assign item.radix = radix;
  assign item.neg   = neg;
  assign item.mag   = neg ? (VALUE_W'(0) - value) : value;

  // values under a bad alphabet are dropped here and print nothing
  assign busy = q_full;
  assign push = start && !busy && len_ok && alpha_ok;

endmodule

### rtl/sirp_queue.sv
// short queue of classified values between front and back end
`include "signed_integer_radix_print_macros.svh"
module sirp_queue #(
  parameter int unsigned DEPTH = sirp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sirp_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            valid,
  output sirp_pkg::item_t head
);
  import sirp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign head  = entries[rd_ptr];
  assign valid = (count != '0);
  assign full  = (count == CNT_W'(DEPTH));

  `SIRP_ASSERT_NOW(a_no_overflow, clk, rst, push, !full)
  `SIRP_ASSERT_NOW(a_no_underflow, clk, rst, pop, valid)
  `SIRP_ASSERT_NEXT(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))

endmodule

### rtl/sirp_back.sv
// back end: produces one digit position per cycle, most significant first
`include "signed_integer_radix_print_macros.svh"
module sirp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  sirp_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  input  sirp_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        strobe,
  output logic [sirp_pkg::CHAR_W-1:0] character,
  output logic                        last
);
  import sirp_pkg::*;

  back_state_t        state;
  back_state_t        state_next;
  radix_t             radix;
  logic [WORK_W-1:0]  work;
  logic [WORK_W-1:0]  work_next;
  logic [POS_W-1:0]   pos;
  logic               started;
  logic [DIGIT_W-1:0] digit;
  logic [DIGIT_W-1:0] dec_digit;
  logic [DEC_W-1:0]   mult [10];
  logic [DEC_W-1:0]   dec_rem;
  logic               emit;
  logic               strobe_next;
  logic [CHAR_W-1:0]  character_next;
  logic               last_next;

  // decimal digit: compare remainder against all nine multiples of the place value
  always_comb begin
    mult[0]   = '0;
    dec_digit = '0;
    for (int j = 1; j < 10; j++) begin
      mult[j] = dec_pow(pos[3:0]) * DEC_W'(j);
    end
    for (int j = 1; j < 10; j++) begin
      if ({1'b0, work} >= mult[j]) begin
        dec_digit = DIGIT_W'(j);
      end
    end
    dec_rem = {1'b0, work} - mult[dec_digit];
  end

  // digit at the current position and the work word for the next one
  always_comb begin
    case (radix)
      RADIX_BIN: begin
        digit     = {3'b000, work[VALUE_W-1]};
        work_next = work << 1;
      end
      RADIX_OCT: begin
        digit     = {1'b0, work[WORK_W-1 -: 3]};
        work_next = work << 3;
      end
      RADIX_HEX: begin
        digit     = work[VALUE_W-1 -: 4];
        work_next = work << 4;
      end
      RADIX_DEC: begin
        digit     = dec_digit;
        work_next = dec_rem[WORK_W-1:0];
      end
      default: begin
        digit     = '0;
        work_next = work;
      end
    endcase
  end

  // leading zeros are skipped, the units digit always prints
  assign emit = started || (digit != '0) || (pos == '0);

  // next state
  always_comb begin
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = q_item.neg ? BK_SIGN : BK_DIGIT;
        end else begin
          state_next = BK_IDLE;
        end
      end
      BK_SIGN:  state_next = BK_DIGIT;
      BK_DIGIT: state_next = (pos == '0) ? BK_IDLE : BK_DIGIT;
      default:  state_next = BK_IDLE;
    endcase
  end

  // outputs per state
  always_comb begin
    q_pop          = 1'b0;
    strobe_next    = 1'b0;
    character_next = alpha_char(cfg, digit);
    last_next      = 1'b0;
    case (state)
      BK_IDLE: q_pop = q_valid;
      BK_SIGN: begin
        strobe_next    = 1'b1;
        character_next = MINUS_CHAR;
      end
      BK_DIGIT: begin
        strobe_next = emit;
        last_next   = (pos == '0);
      end
      default: ;
    endcase
  end

  // state and digit walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      started <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        started <= 1'b0;
      end else if (state == BK_DIGIT && emit) begin
        started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      radix <= q_item.radix;
      work  <= {1'b0, q_item.mag};
      pos   <= top_pos(q_item.radix);
    end else if (state == BK_DIGIT) begin
      work <= work_next;
      pos  <= pos - 1'b1;
    end
  end

  // registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    character <= character_next;
    last      <= last_next;
  end

  `SIRP_ASSERT_NEXT(a_sign_not_last, clk, rst, state == BK_SIGN, strobe && !last)
  `SIRP_ASSERT_NEXT(a_units_is_last, clk, rst, state == BK_DIGIT && pos == '0, strobe && last)
  `SIRP_ASSERT_NEXT(a_gap_after_last, clk, rst, strobe && last, !strobe)

endmodule

### rtl/signed_integer_radix_print.sv
// top level of the signed radix printer
//
//   port group        dir  transaction
//   ----------------  ---  ----------------------------------------------
//   start/busy/value  in   one value taken when start is high, busy low
//   strobe/character  out  one character per strobe cycle, last on final
//   psel..pready      cfg  apb registers at 0x00, 0x08, 0x10 (64-bit data)
//
// a value passes through the queue pop, a minus sign if negative, then the
// back end digit walk, one digit position per cycle over the 32 binary, 11
// octal, 10 decimal or 8 hex positions of the radix. a minus sign or a
// nonzero top digit follows the queue pop and leaves through the registered
// output; leading zero positions before it are walked without a strobe.
// busy is high while the value queue is full; values under a bad alphabet
// are dropped at the front and print nothing.
// reset clears the registers, the queue and the back end; the receiver cannot
// stall, one character leaves per strobe cycle.
module signed_integer_radix_print #(
  parameter int unsigned QUEUE_DEPTH = sirp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [sirp_pkg::VALUE_W-1:0] value,
  output logic                         strobe,
  output logic [sirp_pkg::CHAR_W-1:0]  character,
  output logic                         last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sirp_pkg::ADDR_W-1:0]  paddr,
  input  logic [sirp_pkg::DATA_W-1:0]  pwdata,
  output logic [sirp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import sirp_pkg::*;

  cfg_t  cfg;
  item_t push_item;
  item_t head;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_valid;

  // configuration registers
  sirp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // accept and classify
  sirp_front u_front (
    .start  (start),
    .value  (value),
    .cfg    (cfg),
    .q_full (q_full),
    .busy   (busy),
    .push   (push),
    .item   (push_item)
  );

  // value queue
  sirp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (head)
  );

  // digit generation
  sirp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (head),
    .q_pop     (pop),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

endmodule
